>>> sv/pfi_pkg.sv
// shared constants and types of the polyphase fir interpolator
package pfi_pkg;

	// sizing of the filter
	localparam int MAX_TAPS   = 64;
	localparam int MAX_FACTOR = 8;
	localparam int COEF_DEPTH = 512;
	localparam int HIST_DEPTH = MAX_TAPS - 1;

	// word fields
	localparam int DATA_W     = 16;
	localparam int CIDX_W     = 9;
	localparam int PHASE_W    = 3;
	localparam int IN_TDATA_W = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int FACTOR_W   = 4;
	localparam int TAPS_W     = 7;

	// derived widths
	localparam int COEF_AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int HIDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int HSUM_W  = HIDX_W + 1;
	localparam int FILL_W  = $clog2(HIST_DEPTH + 1);
	localparam int LCNT_W  = $clog2(MAX_FACTOR + 1);
	localparam int KCNT_W  = $clog2(MAX_TAPS + 1);
	localparam int TAPI_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int PHI_W   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int FULL_W  = $clog2(MAX_FACTOR * MAX_TAPS);

	// arithmetic
	localparam int PROD_W     = 2 * DATA_W;
	localparam int PROD_SHIFT = 6;
	localparam int SUM_SHIFT  = 9;
	localparam int TERM_W     = PROD_W - PROD_SHIFT;
	localparam int ACC_W      = TERM_W + $clog2(MAX_TAPS) + 1;
	localparam int SAT_MAX    = 32767;
	localparam int SAT_MIN    = -32768;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd2;

	// input word kinds
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_COEF   = 1'b1;

	// control from the tap sequencer to the multiply-accumulate
	typedef struct packed {
		logic clear;
		logic tap_valid;
	} mac_ctl_t;

endpackage

>>> sv/pfi_ram.sv
// generic simple dual-port ram with registered read
module pfi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> sv/pfi_mac.sv
// shared multiply-accumulate with product and sum scaling and int16 saturation
module pfi_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pfi_pkg::mac_ctl_t                   ctl,
	input  logic signed [pfi_pkg::DATA_W-1:0]   op_sample,
	input  logic signed [pfi_pkg::DATA_W-1:0]   op_coef,
	output logic                                busy,
	output logic signed [pfi_pkg::DATA_W-1:0]   result
);

	logic signed [pfi_pkg::PROD_W-1:0] prod_s2;
	logic                              valid_s2;
	logic signed [pfi_pkg::TERM_W-1:0] term;
	logic signed [pfi_pkg::ACC_W-1:0]  acc_q;
	logic signed [pfi_pkg::ACC_W-1:0]  scaled;

	// product register
	always_ff @(posedge clk) begin
		if (ctl.tap_valid) begin
			prod_s2 <= op_sample * op_coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl.tap_valid;
		end
	end

	// each product floors by the product shift
	assign term = pfi_pkg::TERM_W'(prod_s2 >>> pfi_pkg::PROD_SHIFT);

	// accumulator, cleared at the start of each phase
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + pfi_pkg::ACC_W'(term);
		end
	end

	// final scaling and saturation
	assign scaled = acc_q >>> pfi_pkg::SUM_SHIFT;

	always_comb begin
		if (scaled > pfi_pkg::SAT_MAX) begin
			result = pfi_pkg::DATA_W'(pfi_pkg::SAT_MAX);
		end else if (scaled < pfi_pkg::SAT_MIN) begin
			result = pfi_pkg::DATA_W'(pfi_pkg::SAT_MIN);
		end else begin
			result = pfi_pkg::DATA_W'(scaled);
		end
	end

	assign busy = valid_s2;

endmodule

>>> sv/polyphase_fir_interpolator.sv
// top level of the polyphase fir interpolator
//
// channel   direction  handshake          contents
// s_*       in         tvalid/tready      sample push or coefficient write word
// m_*       out        tvalid/tready      one interpolated output per phase
// cfg_*     in         cfg_we only        upsample factor, taps per phase, layout
//
// a sample word is worked through phase by phase: one tap per cycle through the
// shared multiplier, then the tap pipeline drains and the result is emitted for
// each phase; a coefficient word is written without leaving idle
// the coefficient and history rams each have one read port, which sets the tap rate
// history reads as zero after reset through a fill count; no clearing pass
// s_tready is high only while idle; the output register lets the next word
// be taken while the last result still waits, and a stalled output holds
// the sequencer before loading the next phase
module polyphase_fir_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	// input word
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sample_in [15:0], coef_index [24:16], coef_value [40:25]
	input  logic [pfi_pkg::IN_TDATA_W-1:0]     s_tdata,
	// func [0]
	input  logic                               s_tuser,
	// output word
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// sample_out [15:0]
	output logic [pfi_pkg::DATA_W-1:0]         m_tdata,
	// phase [2:0]
	output logic [pfi_pkg::PHASE_W-1:0]        m_tuser,
	output logic                               m_tlast,
	// configuration
	input  logic                               cfg_we,
	input  logic [pfi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;

	// configuration registers
	logic [pfi_pkg::FACTOR_W-1:0] factor_q;
	logic [pfi_pkg::TAPS_W-1:0]   taps_q;
	logic                         layout_q;

	// per-sample latched values
	logic signed [pfi_pkg::DATA_W-1:0] x_q;
	logic [pfi_pkg::LCNT_W-1:0]        l_q;
	logic [pfi_pkg::KCNT_W-1:0]        k_q;
	logic                              lay_q;

	// sequencer counters
	logic [pfi_pkg::PHI_W-1:0]  phase_q;
	logic [pfi_pkg::TAPI_W-1:0] tap_q;
	logic [pfi_pkg::TAPI_W-1:0] dist_q;
	logic [pfi_pkg::FULL_W-1:0] caddr_q;
	logic [pfi_pkg::FULL_W-1:0] base_q;

	// history ring
	logic [pfi_pkg::HIDX_W-1:0] ptr_q;
	logic [pfi_pkg::FILL_W-1:0] fill_q;

	// tap pipeline
	logic valid_s1;
	logic use_x_s1;
	logic zero_s1;

	// output register
	logic                               out_valid_q;
	logic [pfi_pkg::DATA_W-1:0]         out_data_q;
	logic [pfi_pkg::PHASE_W-1:0]        out_phase_q;
	logic                               out_last_q;

	// combinational
	logic                               accept;
	logic                               is_coef;
	logic [pfi_pkg::LCNT_W-1:0]         l_clamp;
	logic [pfi_pkg::KCNT_W-1:0]         k_clamp;
	logic [pfi_pkg::TAPI_W-1:0]         k_last;
	logic [pfi_pkg::TAPI_W-1:0]         k_last_cfg;
	logic                               last_tap;
	logic                               last_phase;
	logic                               out_free;
	logic                               emit;
	logic [pfi_pkg::FULL_W-1:0]         next_base;
	logic [pfi_pkg::HSUM_W-1:0]         hsum;
	logic [pfi_pkg::HSUM_W-1:0]         hwrap;
	logic [pfi_pkg::HIDX_W-1:0]         hidx;
	logic                               hvalid;
	logic [pfi_pkg::CIDX_W-1:0]         in_cidx;
	logic                               coef_we;
	logic [pfi_pkg::DATA_W-1:0]         hist_rdata;
	logic [pfi_pkg::DATA_W-1:0]         coef_rdata;
	logic signed [pfi_pkg::DATA_W-1:0]  op_sample;
	logic                               hist_we;
	pfi_pkg::mac_ctl_t                  mac_ctl;
	logic signed [pfi_pkg::DATA_W-1:0]  mac_result;
	logic                               mac_busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= pfi_pkg::FACTOR_W'(2);
			taps_q   <= pfi_pkg::TAPS_W'(16);
			layout_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfi_pkg::CFG_FACTOR: factor_q <= cfg_wdata[pfi_pkg::FACTOR_W-1:0];
				pfi_pkg::CFG_TAPS:   taps_q   <= cfg_wdata[pfi_pkg::TAPS_W-1:0];
				pfi_pkg::CFG_LAYOUT: layout_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamp factor and taps into their legal ranges
	always_comb begin
		if (factor_q == '0) begin
			l_clamp = pfi_pkg::LCNT_W'(1);
		end else if (factor_q > pfi_pkg::MAX_FACTOR) begin
			l_clamp = pfi_pkg::LCNT_W'(pfi_pkg::MAX_FACTOR);
		end else begin
			l_clamp = pfi_pkg::LCNT_W'(factor_q);
		end
		if (taps_q == '0) begin
			k_clamp = pfi_pkg::KCNT_W'(1);
		end else if (taps_q > pfi_pkg::MAX_TAPS) begin
			k_clamp = pfi_pkg::KCNT_W'(pfi_pkg::MAX_TAPS);
		end else begin
			k_clamp = pfi_pkg::KCNT_W'(taps_q);
		end
	end

	assign k_last_cfg = pfi_pkg::TAPI_W'(k_clamp - pfi_pkg::KCNT_W'(1));
	assign k_last     = pfi_pkg::TAPI_W'(k_q - pfi_pkg::KCNT_W'(1));
	assign last_tap   = (tap_q == k_last);
	assign last_phase = (pfi_pkg::LCNT_W'(phase_q) == l_q - pfi_pkg::LCNT_W'(1));

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_coef  = (s_tuser == pfi_pkg::FUNC_COEF);
	assign out_free = !out_valid_q || m_tready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	// coefficient writes beyond the table are dropped
	assign in_cidx = s_tdata[24:16];
	assign coef_we = accept && is_coef &&
		((pfi_pkg::COEF_AW + 1)'(in_cidx) < (pfi_pkg::COEF_AW + 1)'(pfi_pkg::COEF_DEPTH));

	// start address of the next phase
	assign next_base = lay_q ? (base_q + pfi_pkg::FULL_W'(1))
	                         : (base_q + pfi_pkg::FULL_W'(k_q));

	// history slot for the current distance back in time
	assign hsum  = pfi_pkg::HSUM_W'(ptr_q) + pfi_pkg::HSUM_W'(pfi_pkg::HIST_DEPTH)
	             - pfi_pkg::HSUM_W'(dist_q);
	assign hwrap = (hsum >= pfi_pkg::HSUM_W'(pfi_pkg::HIST_DEPTH))
	             ? (hsum - pfi_pkg::HSUM_W'(pfi_pkg::HIST_DEPTH)) : hsum;
	assign hidx   = pfi_pkg::HIDX_W'(hwrap);
	assign hvalid = (pfi_pkg::FILL_W'(hidx) < fill_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			tap_q   <= '0;
			dist_q  <= '0;
			caddr_q <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !is_coef) begin
						state_q <= ST_RUN;
						phase_q <= '0;
						tap_q   <= '0;
						caddr_q <= '0;
						base_q  <= '0;
						dist_q  <= layout_q ? '0 : k_last_cfg;
					end
				end
				ST_RUN: begin
					tap_q   <= tap_q + pfi_pkg::TAPI_W'(1);
					caddr_q <= lay_q ? (caddr_q + pfi_pkg::FULL_W'(l_q))
					                 : (caddr_q + pfi_pkg::FULL_W'(1));
					dist_q  <= lay_q ? (dist_q + pfi_pkg::TAPI_W'(1))
					                 : (dist_q - pfi_pkg::TAPI_W'(1));
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (last_phase) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							phase_q <= phase_q + pfi_pkg::PHI_W'(1);
							tap_q   <= '0;
							base_q  <= next_base;
							caddr_q <= next_base;
							dist_q  <= lay_q ? '0 : k_last;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latch the sample and the clamped configuration
	always_ff @(posedge clk) begin
		if (accept && !is_coef) begin
			x_q   <= s_tdata[pfi_pkg::DATA_W-1:0];
			l_q   <= l_clamp;
			k_q   <= k_clamp;
			lay_q <= layout_q;
		end
	end

	// history ring pointer and fill count, advanced after the last phase
	assign hist_we = emit && last_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (hist_we) begin
			ptr_q <= (ptr_q == pfi_pkg::HIDX_W'(pfi_pkg::HIST_DEPTH - 1))
			       ? '0 : (ptr_q + pfi_pkg::HIDX_W'(1));
			if (fill_q != pfi_pkg::FILL_W'(pfi_pkg::HIST_DEPTH)) begin
				fill_q <= fill_q + pfi_pkg::FILL_W'(1);
			end
		end
	end

	// tap pipeline stage one: ram read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		use_x_s1 <= (dist_q == '0);
		zero_s1  <= !hvalid;
	end

	pfi_ram #(
		.WIDTH(pfi_pkg::DATA_W),
		.DEPTH(pfi_pkg::HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (ptr_q),
		.wdata (x_q),
		.raddr (hidx),
		.rdata (hist_rdata)
	);

	pfi_ram #(
		.WIDTH(pfi_pkg::DATA_W),
		.DEPTH(pfi_pkg::COEF_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (pfi_pkg::COEF_AW'(in_cidx)),
		.wdata (s_tdata[40:25]),
		.raddr (pfi_pkg::COEF_AW'(caddr_q)),
		.rdata (coef_rdata)
	);

	// sample operand: current sample, stored history or unwritten zero
	always_comb begin
		if (use_x_s1) begin
			op_sample = x_q;
		end else if (zero_s1) begin
			op_sample = '0;
		end else begin
			op_sample = hist_rdata;
		end
	end

	assign mac_ctl.clear     = (accept && !is_coef) || (emit && !last_phase);
	assign mac_ctl.tap_valid = valid_s1;

	pfi_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.op_sample (op_sample),
		.op_coef   (coef_rdata),
		.busy      (mac_busy),
		.result    (mac_result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q  <= mac_result;
			out_phase_q <= pfi_pkg::PHASE_W'(phase_q);
			out_last_q  <= last_phase;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_phase_q;
	assign m_tlast  = out_last_q;

endmodule
